### rtl/qs_pkg.sv
// Shared types for the quicksort sorter.
// Holds the controller state encoding and the output stage control word.
// No dependencies.
package qs_pkg;

  typedef enum logic [12:0] {
    ST_LOAD     = 13'b0000000000001,
    ST_RANGE    = 13'b0000000000010,
    ST_POP_WAIT = 13'b0000000000100,
    ST_RD_HI    = 13'b0000000001000,
    ST_SWAP1    = 13'b0000000010000,
    ST_SWAP2    = 13'b0000000100000,
    ST_SCAN     = 13'b0000001000000,
    ST_XCHG_A   = 13'b0000010000000,
    ST_XCHG_B   = 13'b0000100000000,
    ST_FIN_A    = 13'b0001000000000,
    ST_FIN_B    = 13'b0010000000000,
    ST_OUT_RD   = 13'b0100000000000,
    ST_OUT_WR   = 13'b1000000000000
  } qs_state_e;

  typedef struct packed {
    logic load;
    logic last;
  } qs_out_ctl_t;

endpackage

### rtl/qs_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered and appears in the cycle after the address.
// No dependencies.
module qs_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/qs_out_reg.sv
// Output register stage of the quicksort sorter.
// Holds one result word until the consumer takes it; depends on qs_pkg.
module qs_out_reg #(
  parameter int unsigned ValueWidth = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  qs_pkg::qs_out_ctl_t       ctl_i,
  input  logic [ValueWidth-1:0]     data_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [ValueWidth-1:0]     data_o,
  output logic                      last_o
);

  import qs_pkg::*;

  logic                  valid_q, valid_d;
  logic [ValueWidth-1:0] data_q;
  logic                  last_q;

  always_comb begin
    valid_d = valid_q;
    if (ctl_i.load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      data_q <= data_i;
      last_q <= ctl_i.last;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = last_q;

endmodule

### rtl/quicksort_sorter.sv
// Quicksort sorter: words are loaded one per cycle while in_ready_o is high into an
// element RAM, and the word flagged last starts an in-place quicksort (middle pivot,
// Lomuto partition, explicit range stack in a second RAM, smaller side first). Words
// beyond MAX_COUNT are dropped. Each partition runs setup states, then scans word by
// word; an exchange adds ST_XCHG_A and ST_XCHG_B because the element RAM has a
// single read and a single write port, and a stack pop adds ST_POP_WAIT. The sorted
// set then drains word by word via ST_OUT_RD and ST_OUT_WR, waiting while the output
// register is full, the final word marked with last_out_o. Input is taken again once
// the final word sits in the output register. Depends on qs_pkg, qs_ram and qs_out_reg.
module quicksort_sorter #(
  parameter int unsigned MAX_COUNT   = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          is_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] sorted_value_o,
  output logic                          last_out_o
);

  import qs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_COUNT);
  localparam int unsigned CW = $clog2(MAX_COUNT + 1);
  localparam int unsigned PW = IW + 2;

  qs_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] sp_q, sp_d;
  logic [CW-1:0] k_q, k_d;
  logic signed [PW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IW-1:0] i_q, i_d, idx_q, idx_d;
  logic signed [VALUE_WIDTH-1:0] pivot_q, pivot_d, vi_q, vi_d;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                stk_we;
  logic [IW-1:0]       stk_waddr, stk_raddr;
  logic [2*IW-1:0]     stk_wdata, stk_rdata;

  qs_out_ctl_t            out_ctl;
  logic [VALUE_WIDTH-1:0] out_data;
  logic [VALUE_WIDTH-1:0] out_q;

  qs_ram #(
    .Depth (MAX_COUNT),
    .Width (VALUE_WIDTH)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  qs_ram #(
    .Depth (MAX_COUNT),
    .Width (2 * IW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  qs_out_reg #(
    .ValueWidth (VALUE_WIDTH)
  ) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (out_ctl),
    .data_i  (out_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_q),
    .last_o  (last_out_o)
  );

  assign sorted_value_o = $signed(out_q);
  assign in_ready_o     = (state_q == ST_LOAD);

  always_comb begin
    logic [CW-1:0]        cnt_new;
    logic                 room;
    logic [IW-1:0]        lo_idx, hi_idx, diff, i_inc, idx_inc;
    logic                 val_lt;
    logic signed [PW-1:0] p_s, lhi, rlo;
    logic [CW-1:0]        sp_dec;
    logic [CW-1:0]        k_inc;

    room    = (cnt_q < CW'(MAX_COUNT));
    cnt_new = room ? cnt_q + CW'(1) : cnt_q;
    lo_idx  = lo_q[IW-1:0];
    hi_idx  = hi_q[IW-1:0];
    diff    = hi_idx - lo_idx;
    i_inc   = i_q + IW'(1);
    idx_inc = idx_q + IW'(1);
    val_lt  = ($signed(ram_rdata) < pivot_q);
    p_s     = PW'(idx_q);
    lhi     = p_s - PW'(1);
    rlo     = p_s + PW'(1);
    sp_dec  = sp_q - CW'(1);
    k_inc   = k_q + CW'(1);

    state_d = state_q;
    cnt_d   = cnt_q;
    sp_d    = sp_q;
    k_d     = k_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    i_d     = i_q;
    idx_d   = idx_q;
    pivot_d = pivot_q;
    vi_d    = vi_q;

    ram_we    = 1'b0;
    ram_waddr = i_q;
    ram_wdata = ram_rdata;
    ram_raddr = i_q;

    stk_we    = 1'b0;
    stk_waddr = sp_q[IW-1:0];
    stk_wdata = {lo_idx, hi_idx};
    stk_raddr = sp_dec[IW-1:0];

    out_ctl.load = 1'b0;
    out_ctl.last = (k_inc == cnt_q);
    out_data     = ram_rdata;

    unique case (state_q)
      ST_LOAD: begin
        ram_waddr = cnt_q[IW-1:0];
        ram_wdata = value_i;
        if (in_valid_i) begin
          ram_we = room;
          cnt_d  = cnt_new;
          if (is_last_i) begin
            lo_d    = '0;
            hi_d    = PW'(cnt_new) - PW'(1);
            sp_d    = '0;
            state_d = ST_RANGE;
          end
        end
      end
      ST_RANGE: begin
        if (lo_q < hi_q) begin
          idx_d     = lo_idx + (diff >> 1);
          ram_raddr = idx_d;
          state_d   = ST_RD_HI;
        end else if (sp_q != '0) begin
          sp_d    = sp_dec;
          state_d = ST_POP_WAIT;
        end else begin
          k_d     = '0;
          state_d = ST_OUT_RD;
        end
      end
      ST_POP_WAIT: begin
        lo_d    = PW'(stk_rdata[2*IW-1:IW]);
        hi_d    = PW'(stk_rdata[IW-1:0]);
        state_d = ST_RANGE;
      end
      ST_RD_HI: begin
        pivot_d   = $signed(ram_rdata);
        ram_raddr = hi_idx;
        state_d   = ST_SWAP1;
      end
      ST_SWAP1: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        state_d   = ST_SWAP2;
      end
      ST_SWAP2: begin
        ram_we    = 1'b1;
        ram_waddr = hi_idx;
        ram_wdata = pivot_q;
        ram_raddr = lo_idx;
        i_d       = lo_idx;
        idx_d     = lo_idx;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        vi_d = $signed(ram_rdata);
        if (val_lt && (idx_q != i_q)) begin
          ram_raddr = idx_q;
          state_d   = ST_XCHG_A;
        end else begin
          if (val_lt) begin
            idx_d = idx_inc;
          end
          i_d = i_inc;
          if (i_inc < hi_idx) begin
            ram_raddr = i_inc;
          end else begin
            ram_raddr = idx_d;
            state_d   = ST_FIN_A;
          end
        end
      end
      ST_XCHG_A: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
        state_d   = ST_XCHG_B;
      end
      ST_XCHG_B: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = vi_q;
        idx_d     = idx_inc;
        i_d       = i_inc;
        if (i_inc < hi_idx) begin
          ram_raddr = i_inc;
          state_d   = ST_SCAN;
        end else begin
          ram_raddr = idx_inc;
          state_d   = ST_FIN_A;
        end
      end
      ST_FIN_A: begin
        ram_we    = 1'b1;
        ram_waddr = hi_idx;
        ram_wdata = ram_rdata;
        state_d   = ST_FIN_B;
      end
      ST_FIN_B: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = pivot_q;
        if ((lhi - lo_q) < (hi_q - rlo)) begin
          stk_wdata = {rlo[IW-1:0], hi_idx};
          if ((rlo < hi_q) && (sp_q < CW'(MAX_COUNT))) begin
            stk_we = 1'b1;
            sp_d   = sp_q + CW'(1);
          end
          hi_d = lhi;
        end else begin
          stk_wdata = {lo_idx, lhi[IW-1:0]};
          if ((lo_q < lhi) && (sp_q < CW'(MAX_COUNT))) begin
            stk_we = 1'b1;
            sp_d   = sp_q + CW'(1);
          end
          lo_d = rlo;
        end
        state_d = ST_RANGE;
      end
      ST_OUT_RD: begin
        ram_raddr = k_q[IW-1:0];
        if (!out_valid_o || out_ready_i) begin
          state_d = ST_OUT_WR;
        end
      end
      ST_OUT_WR: begin
        out_ctl.load = 1'b1;
        if (k_inc == cnt_q) begin
          cnt_d   = '0;
          state_d = ST_LOAD;
        end else begin
          k_d     = k_inc;
          state_d = ST_OUT_RD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sp_q    <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    i_q     <= i_d;
    idx_q   <= idx_d;
    pivot_q <= pivot_d;
    vi_q    <= vi_d;
  end

endmodule

### verif/quicksort_sorter_tb.sv
`timescale 1ns / 1ps
// Testbench for quicksort_sorter: sends sets of signed words and checks that each set
// returns in ascending order with its final word marked, under random gaps and stalls.
// Depends only on the quicksort_sorter RTL.
module quicksort_sorter_tb;

  localparam int unsigned MAX_COUNT    = 64;
  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 50;

  typedef logic signed [VALUE_WIDTH-1:0] word_t;

  typedef struct {
    word_t value;
    logic  last;
  } sorted_word_t;

  typedef enum int unsigned {
    RDY_ALWAYS,
    RDY_HALF,
    RDY_SPARSE,
    RDY_HOLD
  } ready_mode_e;

  localparam word_t WORD_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic  clk          = 1'b0;
  logic  rst_n        = 1'b0;
  logic  in_valid     = 1'b0;
  logic  in_ready;
  word_t value        = '0;
  logic  is_last      = 1'b0;
  logic  out_valid;
  logic  out_ready    = 1'b0;
  word_t sorted_value;
  logic  last_out;

  word_t        held_set[$];
  sorted_word_t expected_words[$];
  sorted_word_t head_word;
  int unsigned  cycle_count = 0;
  int unsigned  error_count = 0;
  int unsigned  burst_left  = 0;
  int unsigned  ready_left  = 0;
  ready_mode_e  ready_mode  = RDY_ALWAYS;

  quicksort_sorter #(
    .MAX_COUNT  (MAX_COUNT),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .value_i       (value),
    .is_last_i     (is_last),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .sorted_value_o(sorted_value),
    .last_out_o    (last_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_left = $urandom_range(4, 60);
    end
    ready_left--;
    case (ready_mode)
      RDY_ALWAYS: begin
        out_ready <= 1'b1;
      end
      RDY_HALF: begin
        out_ready <= ($urandom_range(0, 1) == 0);
      end
      RDY_SPARSE: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        out_ready <= 1'b0;
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: sorted_value %0d, last_out %0b", sorted_value, last_out);
        error_count++;
      end else begin
        head_word = expected_words.pop_front();
        if (sorted_value !== head_word.value) begin
          $error("sorted_value: expected %0d, actual %0d", head_word.value, sorted_value);
          error_count++;
        end
        if (last_out !== head_word.last) begin
          $error("last_out: expected %0b, actual %0b", head_word.last, last_out);
          error_count++;
        end
      end
    end
  end

  // Keeps the held set in ascending order; a full store drops the word.
  task automatic sorter_accept(input word_t v, input logic last);
    int unsigned  pos;
    sorted_word_t w;
    if (held_set.size() < MAX_COUNT) begin
      pos = 0;
      while (pos < held_set.size() && held_set[pos] <= v) pos++;
      held_set.insert(pos, v);
    end
    if (last) begin
      foreach (held_set[k]) begin
        w.value = held_set[k];
        w.last  = (k == held_set.size() - 1);
        expected_words.push_back(w);
      end
      held_set.delete();
    end
  endtask

  task automatic send_word(input word_t v, input logic last);
    in_valid <= 1'b1;
    value    <= v;
    is_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sorter_accept(v, last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_set(input word_t vals[$]);
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic word_t rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7: return word_t'($urandom_range(0, 8)) - 4;
      8: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      default: begin
        if ($urandom_range(0, 1)) return WORD_MAX - word_t'($urandom_range(0, 3));
        return WORD_MIN + word_t'($urandom_range(0, 3));
      end
    endcase
  endfunction

  task automatic test_single_word();
    word_t vals[$];
    vals = {WORD_MIN};
    send_set(vals);
    vals = {WORD_MAX};
    send_set(vals);
    vals = {word_t'(0)};
    send_set(vals);
  endtask

  task automatic test_extremes();
    word_t vals[$];
    vals = {WORD_MAX, WORD_MIN, word_t'(0), word_t'(-1), word_t'(1), WORD_MAX, WORD_MIN,
            word_t'(2)};
    send_set(vals);
  endtask

  task automatic test_duplicates();
    word_t vals[$];
    vals = {word_t'(5), word_t'(5), word_t'(5), word_t'(5)};
    send_set(vals);
  endtask

  task automatic test_presorted();
    word_t vals[$];
    vals = {word_t'(-3), word_t'(0), word_t'(9)};
    send_set(vals);
    vals = {word_t'(40), word_t'(7), word_t'(-1), WORD_MIN};
    send_set(vals);
  endtask

  task automatic test_random_sets();
    word_t       vals[$];
    int unsigned n;
    for (int s = 0; s < 16; s++) begin
      vals.delete();
      n = $urandom_range(1, 12);
      repeat (n) vals.push_back(rand_value());
      send_set(vals);
      // Hold off input once until the whole set has drained.
      if (s == 7) wait_drained();
    end
  endtask

  task automatic test_store_overflow();
    word_t vals[$];
    repeat (MAX_COUNT) vals.push_back(rand_value());
    send_set(vals);
    vals.delete();
    repeat (MAX_COUNT + 3) vals.push_back(rand_value());
    send_set(vals);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_word();
    test_extremes();
    test_duplicates();
    test_presorted();
    test_random_sets();
    test_store_overflow();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/qs_pkg.sv
rtl/qs_ram.sv
rtl/qs_out_reg.sv
rtl/quicksort_sorter.sv
verif/quicksort_sorter_tb.sv
